// ===== rtl/pf2rgba_pkg.sv =====
// Package: shared types, format codes and conversion functions for the pixel unpacker.
package pf2rgba_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int HELD_W      = 24;
    localparam int FMT_W       = 5;
    localparam int POS_W       = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    // Format codes
    localparam logic [FMT_W-1:0] FMT_GRAY8    = 5'd0;
    localparam logic [FMT_W-1:0] FMT_BGR_BASE = 5'd1;
    localparam logic [FMT_W-1:0] FMT_RGB_BASE = 5'd11;
    localparam logic [FMT_W-1:0] FMT_LAST     = 5'd20;
    localparam logic [FMT_W-1:0] FMT_RESET    = 5'd7;

    // Register index
    localparam logic REG_SRC_FORMAT = 1'b0;

    typedef enum logic [2:0] {
        KIND_GRAY = 3'd0,
        KIND_555X = 3'd1,
        KIND_565  = 3'd2,
        KIND_888  = 3'd3,
        KIND_888X = 3'd4,
        KIND_4444 = 3'd5,
        KIND_5551 = 3'd6,
        KIND_8888 = 3'd7
    } kind_t;

    // Layout index within a colour order
    typedef enum logic [3:0] {
        SUB_555X   = 4'd0,
        SUB_565    = 4'd1,
        SUB_888    = 4'd2,
        SUB_888X   = 4'd3,
        SUB_4444   = 4'd4,
        SUB_5551   = 4'd5,
        SUB_8888   = 4'd6,
        SUB_N4444  = 4'd7,
        SUB_N5551  = 4'd8,
        SUB_N8888  = 4'd9
    } sub_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  inv;
        logic  rgb;
    } fmt_t;

    // One assembled pixel waiting for conversion
    typedef struct packed {
        logic [WORD_W-1:0] word;
        kind_t             kind;
        logic              inv;
        logic              rgb;
    } item_t;

    // Output pixel, red in the low byte
    typedef struct packed {
        logic [BYTE_W-1:0] alpha;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
    } pixel_t;

    function automatic fmt_t decode_format(input logic [FMT_W-1:0] code);
        fmt_t       f;
        logic [3:0] sub;
        f.valid = 1'b1;
        f.kind  = KIND_GRAY;
        f.inv   = 1'b0;
        f.rgb   = (code >= FMT_RGB_BASE);
        sub     = f.rgb ? 4'(code - FMT_RGB_BASE) : 4'(code - FMT_BGR_BASE);
        if (code == FMT_GRAY8) begin
            f.rgb = 1'b0;
        end else if (code > FMT_LAST) begin
            f.valid = 1'b0;
        end else begin
            case (sub_t'(sub))
                SUB_555X:  f.kind = KIND_555X;
                SUB_565:   f.kind = KIND_565;
                SUB_888:   f.kind = KIND_888;
                SUB_888X:  f.kind = KIND_888X;
                SUB_4444:  f.kind = KIND_4444;
                SUB_5551:  f.kind = KIND_5551;
                SUB_8888:  f.kind = KIND_8888;
                SUB_N4444: begin f.kind = KIND_4444; f.inv = 1'b1; end
                SUB_N5551: begin f.kind = KIND_5551; f.inv = 1'b1; end
                default:   begin f.kind = KIND_8888; f.inv = 1'b1; end
            endcase
        end
        return f;
    endfunction

    // Bytes per pixel for each layout
    function automatic logic [2:0] kind_bytes(input kind_t k);
        logic [2:0] n;
        case (k)
            KIND_GRAY:                       n = 3'd1;
            KIND_888:                        n = 3'd3;
            KIND_888X, KIND_8888:            n = 3'd4;
            default:                         n = 3'd2;
        endcase
        return n;
    endfunction

    function automatic pixel_t convert(input item_t it);
        pixel_t            p;
        logic [BYTE_W-1:0] c0;
        logic [BYTE_W-1:0] c1;
        logic [BYTE_W-1:0] c2;
        logic [BYTE_W-1:0] a;
        logic [15:0]       w;
        w = it.word[15:0];
        case (it.kind)
            KIND_GRAY: begin
                c0 = it.word[7:0];
                c1 = it.word[7:0];
                c2 = it.word[7:0];
                a  = 8'hFF;
            end
            KIND_555X, KIND_5551: begin
                c0 = {w[4:0], 3'b000};
                c1 = {w[9:5], 3'b000};
                c2 = {w[14:10], 3'b000};
                a  = (it.kind == KIND_5551) ? {BYTE_W{w[15]}} : 8'hFF;
            end
            KIND_565: begin
                c0 = {w[4:0], 3'b000};
                c1 = {w[10:5], 2'b00};
                c2 = {w[15:11], 3'b000};
                a  = 8'hFF;
            end
            KIND_4444: begin
                c0 = {w[3:0], 4'h0};
                c1 = {w[7:4], 4'h0};
                c2 = {w[11:8], 4'h0};
                a  = {w[15:12], 4'h0};
            end
            default: begin
                c0 = it.word[7:0];
                c1 = it.word[15:8];
                c2 = it.word[23:16];
                a  = (it.kind == KIND_8888) ? it.word[31:24] : 8'hFF;
            end
        endcase
        if (it.inv) begin
            a = ~a;
        end
        p.red   = it.rgb ? c0 : c2;
        p.green = c1;
        p.blue  = it.rgb ? c2 : c0;
        p.alpha = a;
        return p;
    endfunction

endpackage

// ===== rtl/pixel_format_to_rgba8888.sv =====
// Top level: packed pixel byte stream to RGBA8888 pixels, with APB format register.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] in_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata red, green, blue, alpha
//  apb       in   psel/penable/pwrite, pready  source format at address 0
//
// One byte is taken per cycle when the four-entry pixel queue has room; a
// pixel passes from its last byte through the queue, then the output register.
// Throughput is one byte per cycle while the queue has room.
// Reset clears the byte gatherer, queue and output valid; format resets to
// BGRA8888. Output stalls fill the queue, then stop s_axis_tready.
// A write to the format register drops any partly gathered pixel.
module pixel_format_to_rgba8888 (
    input  logic                                clk,
    input  logic                                rst_n,
    // slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pf2rgba_pkg::BYTE_W-1:0]      s_axis_tdata,   // [7:0] in_byte
    // master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pf2rgba_pkg::WORD_W-1:0]      m_axis_tdata,   // [7:0] red, [15:8] green,
                                                                // [23:16] blue, [31:24] alpha
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pf2rgba_pkg::ADDR_W-1:0]      paddr,
    input  logic [pf2rgba_pkg::DATA_W-1:0]      pwdata,
    output logic [pf2rgba_pkg::DATA_W-1:0]      prdata,
    output logic                                pready
);
    import pf2rgba_pkg::*;

    logic [FMT_W-1:0] format_reg;
    logic [FMT_W-1:0] format_next;
    logic             cfg_write;
    logic             fmt_clear;
    logic             push;
    item_t            push_item;
    logic             queue_ready;
    logic             pop;
    logic             pop_valid;
    item_t            pop_item;
    pixel_t           out_pixel;

    // APB: always ready, register index taken from the word address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign fmt_clear = cfg_write && (paddr[2] == REG_SRC_FORMAT);
    assign prdata    = (paddr[2] == REG_SRC_FORMAT)
                     ? {{(DATA_W-FMT_W){1'b0}}, format_reg} : '0;

    always_comb
    begin
        format_next = format_reg;
        if (fmt_clear) begin
            format_next = pwdata[FMT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            format_reg <= FMT_RESET;
        end else begin
            format_reg <= format_next;
        end
    end

    pf2rgba_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_format   (format_reg),
        .fmt_clear    (fmt_clear),
        .byte_valid   (s_axis_tvalid),
        .byte_data    (s_axis_tdata),
        .byte_ready   (s_axis_tready),
        .push         (push),
        .push_item    (push_item),
        .queue_ready  (queue_ready)
    );

    pf2rgba_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (queue_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item)
    );

    pf2rgba_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pop_valid),
        .item       (pop_item),
        .item_pop   (pop),
        .out_valid  (m_axis_tvalid),
        .out_pixel  (out_pixel),
        .out_ready  (m_axis_tready)
    );

    assign m_axis_tdata = out_pixel;

endmodule

// ===== rtl/pf2rgba_front.sv =====
// Front end: gathers stream bytes into whole pixels and tags them with their layout.
module pf2rgba_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [pf2rgba_pkg::FMT_W-1:0]    src_format,
    input  logic                             fmt_clear,
    input  logic                             byte_valid,
    input  logic [pf2rgba_pkg::BYTE_W-1:0]   byte_data,
    output logic                             byte_ready,
    output logic                             push,
    output pf2rgba_pkg::item_t               push_item,
    input  logic                             queue_ready
);
    import pf2rgba_pkg::*;

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [HELD_W-1:0] held_reg;
    logic [HELD_W-1:0] held_next;
    fmt_t              fmt;
    logic [WORD_W-1:0] word;
    logic              accept;
    logic              complete;

    assign fmt        = decode_format(src_format);
    assign byte_ready = queue_ready;
    assign accept     = byte_valid && queue_ready;
    assign word       = {{(WORD_W-HELD_W){1'b0}}, held_reg}
                      | ({{(WORD_W-BYTE_W){1'b0}}, byte_data} << {pos_reg, 3'b000});
    assign complete   = ({1'b0, pos_reg} + 3'd1) >= kind_bytes(fmt.kind);

    assign push           = accept && fmt.valid && complete;
    assign push_item.word = word;
    assign push_item.kind = fmt.kind;
    assign push_item.inv  = fmt.inv;
    assign push_item.rgb  = fmt.rgb;

    always_comb
    begin
        pos_next  = pos_reg;
        held_next = held_reg;
        if (fmt_clear) begin
            pos_next  = '0;
            held_next = '0;
        end else if (accept) begin
            if (!fmt.valid || complete) begin
                pos_next  = '0;
                held_next = '0;
            end else begin
                pos_next  = pos_reg + 2'd1;
                held_next = word[HELD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= '0;
            held_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            held_reg <= held_next;
        end
    end

endmodule

// ===== rtl/pf2rgba_queue.sv =====
// Short FIFO between the byte gatherer and the converter.
module pf2rgba_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pf2rgba_pkg::item_t push_item,
    output logic               push_ready,
    input  logic               pop,
    output logic               pop_valid,
    output pf2rgba_pkg::item_t pop_item
);
    import pf2rgba_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/pf2rgba_back.sv =====
// Back end: expands a queued pixel to RGBA8888 into the output register.
module pf2rgba_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  pf2rgba_pkg::item_t item,
    output logic               item_pop,
    output logic               out_valid,
    output pf2rgba_pkg::pixel_t out_pixel,
    input  logic               out_ready
);
    import pf2rgba_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    pixel_t pixel_reg;
    logic   load;

    assign load      = item_valid && (!valid_reg || out_ready);
    assign item_pop  = load;
    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            pixel_reg <= convert(item);
        end
    end

endmodule
